// ===== hw/rtl/tun_pkg.sv =====
// Shared constants for the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;

  // Radicand bits consumed by one square root stage.
  localparam int unsigned SQRT_DIGIT_BITS = 2;
  // Trial pattern appended to the partial root in each square root stage.
  localparam logic [SQRT_DIGIT_BITS-1:0] SQRT_TRIAL_LSB = 2'b01;
  // Default coordinate width and normal fraction bits of the channels.
  localparam int unsigned DEF_COORD_WIDTH = 16;
  localparam int unsigned DEF_NORMAL_FRAC_BITS = 14;

endpackage

// ===== hw/rtl/tun_in_if.sv =====
// Input channel: three triangle vertices, valid/ready handshake.
`timescale 1ns / 1ps
interface tun_in_if import tun_pkg::*; #(
  parameter int unsigned CW = DEF_COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] p0_x;
  logic signed [CW-1:0] p0_y;
  logic signed [CW-1:0] p0_z;
  logic signed [CW-1:0] p1_x;
  logic signed [CW-1:0] p1_y;
  logic signed [CW-1:0] p1_z;
  logic signed [CW-1:0] p2_x;
  logic signed [CW-1:0] p2_y;
  logic signed [CW-1:0] p2_z;

  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  input ready);
  modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                output ready);
endinterface

// ===== hw/rtl/tun_out_if.sv =====
// Output channel: unit normal and degenerate flag, valid/ready handshake.
`timescale 1ns / 1ps
interface tun_out_if import tun_pkg::*; #(
  parameter int unsigned OW = DEF_NORMAL_FRAC_BITS + 2
);
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] normal_x;
  logic signed [OW-1:0] normal_y;
  logic signed [OW-1:0] normal_z;
  logic                 degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== hw/rtl/triangle_unit_normal_top.sv =====
// Top level of the triangle unit normal pipeline.
`timescale 1ns / 1ps
// Unit face normal of a triangle. Each transaction on tri_i carries three
// signed vertices; the block forms the edges p0-p1 and p1-p2, their exact
// cross product, the floor square root L of its squared length, and each
// component scaled by 2^NORMAL_FRAC_BITS / L, truncated toward zero and
// clamped to +/-1.0. A zero length yields a zero vector with degenerate set.
// Throughput is one transaction per cycle while norm_o does not stall.
// The pipeline holds six front stages (edges, products, cross
// differences, magnitudes, squares, sum), one square root stage per
// root bit with LW = 2*COORD_WIDTH + 3 root bits, one divider stage per
// quotient bit (the integer bit among them), and the
// output register. The whole pipeline advances together whenever the
// output register is empty or its transaction is being taken, so a stall
// on norm_o holds every stage and tri_i.ready drops in the same cycle.
module triangle_unit_normal_top import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    tri_i,
  tun_out_if.source norm_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned F  = NORMAL_FRAC_BITS;
  localparam int unsigned EW = CW + 1;      // edge component
  localparam int unsigned PW = 2 * EW;      // edge product
  localparam int unsigned NW = PW + 1;      // cross product component
  localparam int unsigned MW = PW;          // cross product magnitude
  localparam int unsigned LW = MW + 1;      // root width
  localparam int unsigned SW = 2 * LW;      // squared length
  localparam int unsigned RW = LW + 2;      // square root remainder
  localparam int unsigned TW = RW + SQRT_DIGIT_BITS; // square root trial
  localparam int unsigned QW = F + 1;       // quotient
  localparam int unsigned OW = F + 2;       // output component

  localparam logic [QW-1:0] QONE = QW'(1) << F;

  // Global advance: hold everything while the output transaction waits.
  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || norm_o.ready;
  assign tri_i.ready = en;

  // ---------------------------------------------------------------- edges
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];
  assign pa[0] = tri_i.p0_x; assign pa[1] = tri_i.p0_y; assign pa[2] = tri_i.p0_z;
  assign pb[0] = tri_i.p1_x; assign pb[1] = tri_i.p1_y; assign pb[2] = tri_i.p1_z;
  assign pc[0] = tri_i.p2_x; assign pc[1] = tri_i.p2_y; assign pc[2] = tri_i.p2_z;

  logic                 v1_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= tri_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        e1_q[c] <= EW'(pa[c]) - EW'(pb[c]);
        e2_q[c] <= EW'(pb[c]) - EW'(pc[c]);
      end
    end
  end

  // ------------------------------------------------------------- products
  logic                 v2_q;
  logic signed [PW-1:0] pr_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0] <= PW'(e1_q[1]) * PW'(e2_q[2]);
      pr_q[1] <= PW'(e1_q[2]) * PW'(e2_q[1]);
      pr_q[2] <= PW'(e1_q[2]) * PW'(e2_q[0]);
      pr_q[3] <= PW'(e1_q[0]) * PW'(e2_q[2]);
      pr_q[4] <= PW'(e1_q[0]) * PW'(e2_q[1]);
      pr_q[5] <= PW'(e1_q[1]) * PW'(e2_q[0]);
    end
  end

  // -------------------------------------------------- cross product terms
  logic                 v3_q;
  logic signed [NW-1:0] n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        n_q[c] <= NW'(pr_q[2*c]) - NW'(pr_q[2*c+1]);
      end
    end
  end

  // ----------------------------------------------------- magnitude, sign
  logic          v4_q;
  logic [MW-1:0] mag4_q [3];
  logic          neg4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neg4_q[c] <= n_q[c][NW-1];
        mag4_q[c] <= n_q[c][NW-1] ? MW'(-n_q[c]) : MW'(n_q[c]);
      end
    end
  end

  // -------------------------------------------------------------- squares
  logic            v5_q;
  logic [2*MW-1:0] sq5_q [3];
  logic [MW-1:0]   mag5_q [3];
  logic            neg5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq5_q[c]  <= (2*MW)'(mag4_q[c]) * (2*MW)'(mag4_q[c]);
        mag5_q[c] <= mag4_q[c];
        neg5_q[c] <= neg4_q[c];
      end
    end
  end

  // -------------------------------------------------------- square root
  // Index 0 holds the squared length; stage k resolves root bit LW-1-k.
  logic          sr_v   [LW+1];
  logic [SW-1:0] sr_rad [LW+1];
  logic [RW-1:0] sr_rem [LW+1];
  logic [LW-1:0] sr_rt  [LW+1];
  logic          sr_deg [LW+1];
  logic [MW-1:0] sr_mag [LW+1][3];
  logic          sr_neg [LW+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v[0] <= 1'b0;
    end else if (en) begin
      sr_v[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_rad[0] <= SW'(sq5_q[0]) + SW'(sq5_q[1]) + SW'(sq5_q[2]);
      sr_deg[0] <= (sq5_q[0] == '0) && (sq5_q[1] == '0) && (sq5_q[2] == '0);
      sr_rem[0] <= '0;
      sr_rt[0]  <= '0;
      for (int c = 0; c < 3; c++) begin
        sr_mag[0][c] <= mag5_q[c];
        sr_neg[0][c] <= neg5_q[c];
      end
    end
  end

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    localparam int unsigned B = LW - 1 - k;
    logic [TW-1:0] trial;
    logic [TW-1:0] tgt;
    logic          ge;
    assign trial = {sr_rem[k], sr_rad[k][2*B+1 -: SQRT_DIGIT_BITS]};
    assign tgt   = {{(TW-LW-SQRT_DIGIT_BITS){1'b0}}, sr_rt[k], SQRT_TRIAL_LSB};
    assign ge    = trial >= tgt;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v[k+1] <= 1'b0;
      end else if (en) begin
        sr_v[k+1] <= sr_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rad[k+1] <= sr_rad[k];
        sr_rem[k+1] <= ge ? RW'(trial - tgt) : RW'(trial);
        sr_rt[k+1]  <= {sr_rt[k][LW-2:0], ge};
        sr_deg[k+1] <= sr_deg[k];
        for (int c = 0; c < 3; c++) begin
          sr_mag[k+1][c] <= sr_mag[k][c];
          sr_neg[k+1][c] <= sr_neg[k][c];
        end
      end
    end
  end

  // -------------------------------------------------------------- divide
  // Restoring division, one quotient bit per stage, three lanes side by side.
  logic          dv_v   [F+1];
  logic [LW-1:0] dv_len [F+1];
  logic          dv_deg [F+1];
  logic [LW-1:0] dv_rem [F+1][3];
  logic [QW-1:0] dv_quo [F+1][3];
  logic          dv_neg [F+1][3];

  logic [LW-1:0] len_in;
  assign len_in = sr_rt[LW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sr_v[LW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_len[0] <= len_in;
      dv_deg[0] <= sr_deg[LW];
      for (int c = 0; c < 3; c++) begin
        dv_neg[0][c] <= sr_neg[LW][c];
        if ({1'b0, sr_mag[LW][c]} >= len_in) begin
          dv_rem[0][c] <= LW'({1'b0, sr_mag[LW][c]} - len_in);
          dv_quo[0][c] <= QW'(1);
        end else begin
          dv_rem[0][c] <= LW'(sr_mag[LW][c]);
          dv_quo[0][c] <= '0;
        end
      end
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [LW:0] sh;
      if (en) begin
        dv_len[j+1] <= dv_len[j];
        dv_deg[j+1] <= dv_deg[j];
        for (int c = 0; c < 3; c++) begin
          sh = {dv_rem[j][c], 1'b0};
          dv_neg[j+1][c] <= dv_neg[j][c];
          if (sh >= {1'b0, dv_len[j]}) begin
            dv_rem[j+1][c] <= LW'(sh - {1'b0, dv_len[j]});
            dv_quo[j+1][c] <= {dv_quo[j][c][QW-2:0], 1'b1};
          end else begin
            dv_rem[j+1][c] <= LW'(sh);
            dv_quo[j+1][c] <= {dv_quo[j][c][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // -------------------------------------------------------------- output
  // Clamp to 1.0, apply the sign, force zero for a degenerate triangle.
  logic [OW-1:0] res [3];
  always_comb begin
    logic [QW-1:0] qs;
    for (int c = 0; c < 3; c++) begin
      qs     = (dv_quo[F][c] > QONE) ? QONE : dv_quo[F][c];
      res[c] = dv_neg[F][c] ? OW'(-{1'b0, qs}) : OW'({1'b0, qs});
      if (dv_deg[F]) begin
        res[c] = '0;
      end
    end
  end

  logic signed [OW-1:0] nx_q, ny_q, nz_q;
  logic                 deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_v[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= res[0];
      ny_q  <= res[1];
      nz_q  <= res[2];
      deg_q <= dv_deg[F];
    end
  end

  assign norm_o.valid      = out_vld_q;
  assign norm_o.normal_x   = nx_q;
  assign norm_o.normal_y   = ny_q;
  assign norm_o.normal_z   = nz_q;
  assign norm_o.degenerate = deg_q;

endmodule

// ===== tb/triangle_unit_normal_top_tb.sv =====
// Testbench for the triangle unit normal pipeline: directed table, random triangles, scoreboard.
`timescale 1ns / 1ps
module triangle_unit_normal_top_tb;
  import tun_pkg::*;

  localparam int unsigned CW = DEF_COORD_WIDTH;
  localparam int unsigned FB = DEF_NORMAL_FRAC_BITS;
  localparam int unsigned OW = FB + 2;
  localparam int unsigned LATENCY = 6 + (2 * CW + 3) + FB + 2;
  localparam int unsigned N_RANDOM = 900;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CALM_ITEMS = 150;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] comp_t;

  typedef struct packed {
    coord_t p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
  } tri_t;

  typedef struct packed {
    comp_t nx, ny, nz;
    logic  degen;
  } normal_t;

  // One row of the directed table; has_exp marks a hand-written answer.
  typedef struct packed {
    tri_t    vtx;
    logic    has_exp;
    normal_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tun_in_if  #(.CW(CW)) tri_if ();
  tun_out_if #(.OW(OW)) norm_if ();

  triangle_unit_normal_top #(
    .COORD_WIDTH     (CW),
    .NORMAL_FRAC_BITS(FB)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tri_i (tri_if.sink),
    .norm_o(norm_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  normal_t    normal_q[$];
  row_t       table_q[$];
  int unsigned n_fail = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_degen = 0;
  int unsigned cycles = 0;
  bit          send_done = 1'b0;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;

  // Floor square root of an unsigned radicand, bit by bit.
  function automatic logic [127:0] isqrt128(input logic [127:0] n);
    logic [127:0] root;
    logic [127:0] bitv;
    logic [127:0] trial;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      trial = root + bitv;
      if (n >= trial) begin
        n = n - trial;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Unit normal of a triangle: exact cross product, floor length, scaled quotient.
  function automatic normal_t unit_normal(input tri_t t);
    normal_t         r;
    logic signed [127:0] e1[3];
    logic signed [127:0] e2[3];
    logic signed [127:0] n[3];
    logic [127:0]    mag[3];
    logic [127:0]    sum;
    logic [127:0]    len;
    logic [127:0]    q;
    comp_t           c[3];
    e1[0] = 128'(t.p0x) - 128'(t.p1x);
    e1[1] = 128'(t.p0y) - 128'(t.p1y);
    e1[2] = 128'(t.p0z) - 128'(t.p1z);
    e2[0] = 128'(t.p1x) - 128'(t.p2x);
    e2[1] = 128'(t.p1y) - 128'(t.p2y);
    e2[2] = 128'(t.p1z) - 128'(t.p2z);
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
      sum = sum + mag[i] * mag[i];
    end
    if (sum == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
      return r;
    end
    len = isqrt128(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << FB) / len;
      if (q > (128'd1 << FB)) q = 128'd1 << FB;
      c[i] = (n[i] < 0) ? comp_t'(-q) : comp_t'(q);
    end
    r = '{nx: c[0], ny: c[1], nz: c[2], degen: 1'b0};
    return r;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0:       return coord_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1:       return coord_t'($signed($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    coord_t k;
    t = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    // Occasionally make the triangle collapse: repeated or collinear points.
    case ($urandom_range(0, 15))
      0: begin
        t.p1x = t.p0x; t.p1y = t.p0y; t.p1z = t.p0z;
      end
      1: begin
        k = coord_t'($signed($urandom_range(0, 6)) - 3);
        t.p0x = t.p1x + k;
        t.p0y = coord_t'(t.p1y + 2 * k);
        t.p0z = t.p1z - k;
        t.p2x = coord_t'(t.p1x - 2 * k);
        t.p2y = coord_t'(t.p1y - 4 * k);
        t.p2z = coord_t'(t.p1z + 2 * k);
      end
      default: ;
    endcase
    return t;
  endfunction

  // Directed rows; hand answers only for collapsed and axis-aligned cases.
  task automatic add_row(input tri_t t, input logic has, input normal_t e);
    table_q.push_back('{vtx: t, has_exp: has, exp: e});
  endtask

  initial begin
    normal_t none;
    none = '0;
    // Degenerate: all points equal, at the extremes too.
    add_row('{default: '0}, 1'b1, '{nx: '0, ny: '0, nz: '0, degen: 1'b1});
    add_row('{default: 16'sh7fff}, 1'b1, '{nx: '0, ny: '0, nz: '0, degen: 1'b1});
    add_row('{default: 16'sh8000}, 1'b1, '{nx: '0, ny: '0, nz: '0, degen: 1'b1});
    // Collinear points.
    add_row('{0, 0, 0, 256, 256, 256, 512, 512, 512}, 1'b1,
            '{nx: '0, ny: '0, nz: '0, degen: 1'b1});
    // Axis-aligned triangles: unit normals along each axis, both signs along z.
    add_row('{256, 0, 0, 0, 0, 0, 0, 256, 0}, 1'b1,
            '{nx: '0, ny: '0, nz: comp_t'(-16384), degen: 1'b0});
    add_row('{0, 256, 0, 0, 0, 0, 256, 0, 0}, 1'b1,
            '{nx: '0, ny: '0, nz: comp_t'(16384), degen: 1'b0});
    add_row('{0, 256, 0, 0, 0, 0, 0, 0, 256}, 1'b1,
            '{nx: comp_t'(-16384), ny: '0, nz: '0, degen: 1'b0});
    add_row('{0, 0, 256, 0, 0, 0, 256, 0, 0}, 1'b1,
            '{nx: '0, ny: comp_t'(-16384), nz: '0, degen: 1'b0});
    // Extremes of every field: largest edges and products.
    add_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b0, none);
    add_row('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, none);
    add_row('{16'sh8000, 0, 0, 16'sh7fff, 0, 0, 16'sh7fff, 16'sh8000, 0}, 1'b0, none);
    add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, none);
    // Smallest nonzero normal and skewed ones.
    add_row('{1, 0, 0, 0, 0, 0, 0, 1, 0}, 1'b0, none);
    add_row('{1, 1, 0, 0, 0, 0, 0, 16'sh7fff, 1}, 1'b0, none);
    add_row('{-1, -1, -1, 0, 0, 0, 1, -1, 1}, 1'b0, none);
    add_row('{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f, 16'shf0f0,
              16'sh0001, 16'shfffe, 16'sh4000}, 1'b0, none);
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // Abort on a hang.
  always @(posedge clk_i) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("triangle_unit_normal_top_tb failed");
      $finish;
    end
  end

  // Send table rows first, then random triangles, with random idle bursts.
  initial begin
    tri_t t;
    int   idle;
    tri_if.valid <= 1'b0;
    {tri_if.p0_x, tri_if.p0_y, tri_if.p0_z, tri_if.p1_x, tri_if.p1_y, tri_if.p1_z,
     tri_if.p2_x, tri_if.p2_y, tri_if.p2_z} <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < table_q.size() + N_RANDOM; i++) begin
      t = (i < table_q.size()) ? table_q[i].vtx : rnd_tri();
      if (!calm && $urandom_range(0, 7) == 0) begin
        idle = $urandom_range(1, 12);
        tri_if.valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      if (i >= table_q.size() + N_RANDOM - CALM_ITEMS) calm = 1'b1;
      tri_if.valid <= 1'b1;
      {tri_if.p0_x, tri_if.p0_y, tri_if.p0_z, tri_if.p1_x, tri_if.p1_y, tri_if.p1_z,
       tri_if.p2_x, tri_if.p2_y, tri_if.p2_z} <= t;
      // Hold the transaction until it is taken.
      do @(posedge clk_i); while (!tri_if.ready);
      normal_q.push_back((i < table_q.size() && table_q[i].has_exp) ?
                         table_q[i].exp : unit_normal(t));
      n_sent++;
    end
    tri_if.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off to fill the pipeline.
  initial begin
    int idle;
    norm_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (n_sent >= 300 && !hold_long) begin
        hold_long = 1'b1;
        norm_if.ready <= 1'b0;
        for (int c = 0; c < 4 * LATENCY; c++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle = $urandom_range(1, 12);
        norm_if.ready <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      norm_if.ready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && norm_if.valid && norm_if.ready) begin
      n_seen++;
      if (normal_q.size() == 0) begin
        $error("unexpected result transaction");
        n_fail++;
      end else begin
        e = normal_q.pop_front();
        if (e.degen) n_degen++;
        if (norm_if.normal_x !== e.nx) begin
          $error("normal_x expected %0d actual %0d", e.nx, norm_if.normal_x);
          n_fail++;
        end
        if (norm_if.normal_y !== e.ny) begin
          $error("normal_y expected %0d actual %0d", e.ny, norm_if.normal_y);
          n_fail++;
        end
        if (norm_if.normal_z !== e.nz) begin
          $error("normal_z expected %0d actual %0d", e.nz, norm_if.normal_z);
          n_fail++;
        end
        if (norm_if.degenerate !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, norm_if.degenerate);
          n_fail++;
        end
      end
    end
  end

  // Drain, then let the pipeline run empty to catch stray results.
  initial begin
    wait (send_done);
    wait (normal_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (normal_q.size() != 0) begin
      $error("%0d expected results never arrived", normal_q.size());
      n_fail++;
    end
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate),",
             n_sent, n_seen, n_degen);
    $display("with random stalls on both sides and one long output hold-off.");
    if (n_fail == 0) begin
      $display("triangle_unit_normal_top_tb passed");
    end else begin
      $display("triangle_unit_normal_top_tb failed");
    end
    $finish;
  end

endmodule
